// ===== hw/rtl/vmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vmrs_pkg: shared types and constants of the von Mises sampler
// Fixed-point constants, CORDIC arctangent table, register codes, the trial
// record passed from front to back, and the state encodings.
// ----------------------------------------------------------------------------
package vmrs_pkg;

    localparam int          ITERS       = 30;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [36:0] C_LIMIT     = 37'h10_0000_0000;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam int          FIFO_DEPTH  = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MEAN  = 2'd0,
        CFG_KAPPA = 2'd1,
        CFG_ENV_R = 2'd2,
        CFG_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [30:0] mean_angle;
        logic [31:0]        concentration;
        logic [31:0]        envelope_r;
        logic [15:0]        sample_count;
    } cfg_regs_t;

    // one classified draw waiting for the acceptance test
    typedef struct packed {
        logic [36:0]        c;
        logic signed [31:0] f;
        logic [31:0]        draw_two;
        logic [31:0]        draw_three;
    } trial_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [3:0] {
        F_IDLE, F_THETA, F_COS, F_ZVAL, F_PROD, F_MAG, F_CHK,
        F_DIV, F_FVAL, F_DVAL, F_MLO, F_MHI, F_CVAL, F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_CLASS, B_PROD, B_LNORM, B_LSQ, B_LSTORE, B_LMUL,
        B_LEVAL, B_ASQ, B_SQRT, B_VINIT, B_VEC, B_FIN
    } back_state_t;

    // atan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/vmrs_front.sv =====
// ----------------------------------------------------------------------------
// vmrs_front: draw intake and envelope stage
// Takes one draw triple, forms z = cos(pi*u1) by rotation CORDIC,
// f = (1+rz)/(r+z) by restoring division and c = kappa(r-f), drops draws
// with a nonpositive denominator and queues the rest.
// ----------------------------------------------------------------------------
module vmrs_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [95:0]             s_tdata,     // draw_one, draw_two, draw_three
    input  vmrs_pkg::cfg_regs_t     cfg,
    input  vmrs_pkg::fifo_status_t  fifo_status,
    output logic                    push,
    output vmrs_pkg::trial_t        push_data
);
    import vmrs_pkg::*;

    localparam logic signed [64:0] NUM_BIAS = 65'sd1 <<< 46;

    front_state_t state_reg, state_next;

    logic [4:0]         iter_reg;
    logic [31:0]        op_reg;
    logic               zneg_reg;
    logic [31:0]        db_reg;
    logic [31:0]        ds_reg;
    logic signed [33:0] x_reg, y_reg, w_reg;
    logic signed [31:0] z_reg;
    logic signed [64:0] num_reg;
    logic signed [48:0] den_reg;
    logic [63:0]        mag_reg;
    logic               fneg_reg;
    logic               sat_reg;
    logic [77:0]        rem_reg, dsh_reg;
    logic [30:0]        q_reg;
    logic signed [31:0] f_reg;
    logic signed [48:0] d_reg;
    logic [79:0]        acc_reg;
    logic               czero_reg;
    logic [36:0]        c_reg;

    logic               den_bad;
    logic               div_sat;
    logic               div_ge;
    logic signed [33:0] cdx, cdy, cat;
    logic [63:0]        theta_prod;
    logic [30:0]        xc;
    logic [30:0]        fq;
    logic [63:0]        cwide;
    logic [55:0]        mlo;
    logic [54:0]        mhi;

    // shared combinational terms
    always_comb begin
        den_bad    = (den_reg <= 49'sd0);
        div_sat    = (mag_reg >= {den_reg[46:0], 17'd0});
        div_ge     = (rem_reg >= dsh_reg);
        cdx        = y_reg >>> iter_reg;
        cdy        = x_reg >>> iter_reg;
        cat        = $signed({4'b0000, atan_q30(iter_reg)});
        theta_prod = op_reg * PI_Q30;
        if (x_reg[33]) begin
            xc = '0;
        end else if (x_reg > $signed({3'b000, ONE_Q30})) begin
            xc = ONE_Q30;
        end else begin
            xc = x_reg[30:0];
        end
        fq    = (sat_reg || (q_reg > ONE_Q30)) ? ONE_Q30 : q_reg;
        cwide = acc_reg[79:16];
        // kappa times the low and high slices of r - f
        mlo   = cfg.concentration * d_reg[23:0];
        mhi   = cfg.concentration * d_reg[46:24];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_THETA;
            F_THETA: state_next = F_COS;
            F_COS:   if (iter_reg == 5'(ITERS - 1)) state_next = F_ZVAL;
            F_ZVAL:  state_next = F_PROD;
            F_PROD:  state_next = F_MAG;
            F_MAG:   state_next = F_CHK;
            F_CHK: begin
                if (den_bad) begin
                    state_next = F_IDLE;
                end else if (div_sat) begin
                    state_next = F_FVAL;
                end else begin
                    state_next = F_DIV;
                end
            end
            F_DIV:   if (iter_reg == 5'd30) state_next = F_FVAL;
            F_FVAL:  state_next = F_DVAL;
            F_DVAL:  state_next = F_MLO;
            F_MLO:   state_next = F_MHI;
            F_MHI:   state_next = F_CVAL;
            F_CVAL:  state_next = F_PUSH;
            F_PUSH:  if (!fifo_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == F_IDLE);
        push     = (state_reg == F_PUSH) && !fifo_status.full;
        push_data.c          = c_reg;
        push_data.f          = f_reg;
        push_data.draw_two   = db_reg;
        push_data.draw_three = ds_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                // fold the upper half of the cosine argument onto [0, pi/2]
                op_reg   <= s_tdata[31] ? 32'(-s_tdata[31:0]) : s_tdata[31:0];
                zneg_reg <= s_tdata[31];
                db_reg   <= s_tdata[63:32];
                ds_reg   <= s_tdata[95:64];
            end
            F_THETA: begin
                w_reg    <= $signed({2'b00, theta_prod[63:32]});
                x_reg    <= $signed({4'b0000, CORDIC_GAIN});
                y_reg    <= '0;
                iter_reg <= '0;
            end
            F_COS: begin
                if (!w_reg[33]) begin
                    x_reg <= x_reg - cdx;
                    y_reg <= y_reg + cdy;
                    w_reg <= w_reg - cat;
                end else begin
                    x_reg <= x_reg + cdx;
                    y_reg <= y_reg - cdy;
                    w_reg <= w_reg + cat;
                end
                iter_reg <= iter_reg + 5'd1;
            end
            F_ZVAL: begin
                z_reg <= zneg_reg ? -$signed({1'b0, xc}) : $signed({1'b0, xc});
            end
            F_PROD: begin
                num_reg <= ($signed({1'b0, cfg.envelope_r}) * z_reg) + NUM_BIAS;
                den_reg <= $signed({3'b000, cfg.envelope_r, 14'd0}) + 49'(z_reg);
            end
            F_MAG: begin
                fneg_reg <= num_reg[64];
                mag_reg  <= num_reg[64] ? 64'(-num_reg) : num_reg[63:0];
            end
            F_CHK: begin
                sat_reg  <= div_sat;
                rem_reg  <= {mag_reg, 14'd0};
                dsh_reg  <= {1'b0, den_reg[46:0], 30'd0};
                q_reg    <= '0;
                iter_reg <= '0;
            end
            F_DIV: begin
                // one quotient bit per beat
                if (div_ge) rem_reg <= rem_reg - dsh_reg;
                q_reg    <= {q_reg[29:0], div_ge};
                dsh_reg  <= dsh_reg >> 1;
                iter_reg <= iter_reg + 5'd1;
            end
            F_FVAL: begin
                f_reg <= fneg_reg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
            end
            F_DVAL: begin
                d_reg <= $signed({3'b000, cfg.envelope_r, 14'd0}) - 49'(f_reg);
            end
            F_MLO: begin
                czero_reg <= (d_reg <= 49'sd0) || (cfg.concentration == 32'd0);
                acc_reg   <= {24'd0, mlo};
            end
            F_MHI: begin
                acc_reg <= acc_reg + {1'b0, mhi, 24'd0};
            end
            F_CVAL: begin
                if (czero_reg) begin
                    c_reg <= '0;
                end else if (cwide > 64'(C_LIMIT)) begin
                    c_reg <= C_LIMIT;
                end else begin
                    c_reg <= cwide[36:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/vmrs_fifo.sv =====
// ----------------------------------------------------------------------------
// vmrs_fifo: trial queue between front and back
// Small register queue of classified draws so each side can stall alone.
// ----------------------------------------------------------------------------
module vmrs_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  vmrs_pkg::trial_t        push_data,
    input  logic                    pop,
    output vmrs_pkg::trial_t        pop_data,
    output vmrs_pkg::fifo_status_t  status
);
    import vmrs_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    trial_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]   count_reg;

    always_comb begin
        pop_data     = mem_reg[rptr_reg];
        status.full  = (count_reg == CNT_W'(FIFO_DEPTH));
        status.empty = (count_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vmrs_back.sv =====
// ----------------------------------------------------------------------------
// vmrs_back: acceptance test and angle stage
// Pops a trial, runs the quadratic test and if needed the log test (shared
// normalize-and-square log2 unit), then acos(f) by integer root and vectoring
// CORDIC, adds the mean, counts the run and holds the result for the output.
// ----------------------------------------------------------------------------
module vmrs_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vmrs_pkg::cfg_regs_t     cfg,
    input  vmrs_pkg::fifo_status_t  fifo_status,
    input  vmrs_pkg::trial_t        pop_data,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,     // sample_angle
    output logic                    m_tlast      // last_sample
);
    import vmrs_pkg::*;

    localparam int CMP_W = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

    back_state_t state_reg, state_next;

    logic [4:0]             iter_reg;
    logic [36:0]            c_reg;
    logic                   fneg_reg;
    logic [30:0]            a_reg;
    logic [31:0]            db_reg, ds_reg;
    logic [39:0]            lv_reg;
    logic signed [7:0]      le_reg;
    logic [30:0]            lm_reg;
    logic [29:0]            lfrac_reg;
    logic                   lsel_reg;
    logic signed [37:0]     lc_reg;
    logic signed [38:0]     delta_reg;
    logic signed [63:0]     lprod_reg;
    logic [61:0]            n_reg, res_reg, one_reg;
    logic signed [33:0]     x_reg, y_reg, ang_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   out_valid_reg;
    logic [31:0]            out_angle_reg;
    logic                   out_last_reg;

    logic [62:0]            ptest;
    logic                   quad_ok;
    logic [61:0]            sq;
    logic [31:0]            sq_t;
    logic signed [37:0]     l_val;
    logic signed [63:0]     s_val;
    logic [61:0]            rt;
    logic signed [33:0]     vdx, vdy, vat;
    logic [30:0]            angc;
    logic [32:0]            acos_v;
    logic [30:0]            dev;
    logic [31:0]            angle;
    logic [CMP_W-1:0]       next_cnt;
    logic                   last_hit;
    logic                   out_free;

    always_comb begin
        ptest    = c_reg[30:0] * (32'h8000_0000 - {1'b0, c_reg[30:0]});
        quad_ok  = (ptest > {3'b000, db_reg, 28'd0});
        sq       = lm_reg * lm_reg;
        sq_t     = sq[61:30];
        l_val    = {le_reg, lfrac_reg};
        s_val    = (lprod_reg >>> 24) + $signed(64'(ONE_Q30)) - $signed(64'(c_reg));
        rt       = res_reg + one_reg;
        vdx      = y_reg >>> iter_reg;
        vdy      = x_reg >>> iter_reg;
        vat      = $signed({4'b0000, atan_q30(iter_reg)});
        if (ang_reg[33]) begin
            angc = '0;
        end else if (ang_reg > $signed({3'b000, HALF_PI_Q30})) begin
            angc = HALF_PI_Q30;
        end else begin
            angc = ang_reg[30:0];
        end
        acos_v   = fneg_reg ? ({1'b0, PI_Q30} - {2'b00, angc}) : {2'b00, angc};
        dev      = 31'((34'(acos_v) + 34'd2) >> 2);
        angle    = ds_reg[31] ? (32'($signed(cfg.mean_angle)) + {1'b0, dev})
                              : (32'($signed(cfg.mean_angle)) - {1'b0, dev});
        next_cnt = CMP_W'(count_reg) + 1'b1;
        last_hit = (next_cnt >= CMP_W'(cfg.sample_count));
        out_free = !out_valid_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!fifo_status.empty) state_next = B_CLASS;
            B_CLASS: begin
                if (db_reg == 32'd0) begin
                    state_next = B_ASQ;
                end else if (c_reg == '0) begin
                    state_next = B_IDLE;
                end else if (c_reg[36:31] == '0) begin
                    state_next = B_PROD;
                end else begin
                    state_next = B_LNORM;
                end
            end
            B_PROD:   state_next = quad_ok ? B_ASQ : B_LNORM;
            B_LNORM:  if (lv_reg[39]) state_next = B_LSQ;
            B_LSQ:    if (iter_reg == 5'(ITERS - 1)) state_next = B_LSTORE;
            B_LSTORE: state_next = lsel_reg ? B_LMUL : B_LNORM;
            B_LMUL:   state_next = B_LEVAL;
            B_LEVAL:  state_next = s_val[63] ? B_IDLE : B_ASQ;
            B_ASQ:    state_next = B_SQRT;
            B_SQRT:   if (iter_reg == 5'd30) state_next = B_VINIT;
            B_VINIT:  state_next = B_VEC;
            B_VEC:    if (iter_reg == 5'(ITERS - 1)) state_next = B_FIN;
            B_FIN:    if (out_free) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = (state_reg == B_IDLE) && !fifo_status.empty;
        m_tvalid = out_valid_reg;
        m_tdata  = out_angle_reg;
        m_tlast  = out_last_reg;
    end

    // control: state, run counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == B_FIN) && out_free) begin
                out_valid_reg <= 1'b1;
                count_reg     <= last_hit ? '0 : next_cnt[COUNT_BITS-1:0];
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                c_reg    <= pop_data.c;
                fneg_reg <= pop_data.f[31];
                a_reg    <= pop_data.f[31] ? 31'(-pop_data.f) : pop_data.f[30:0];
                db_reg   <= pop_data.draw_two;
                ds_reg   <= pop_data.draw_three;
            end
            B_CLASS, B_PROD: begin
                // log unit set up for ln c first
                lv_reg   <= {3'b000, c_reg};
                le_reg   <= 8'sd9;
                lsel_reg <= 1'b0;
            end
            B_LNORM: begin
                if (lv_reg[39]) begin
                    lm_reg    <= lv_reg[39:9];
                    lfrac_reg <= '0;
                    iter_reg  <= '0;
                end else begin
                    lv_reg <= lv_reg << 1;
                    le_reg <= le_reg - 8'sd1;
                end
            end
            B_LSQ: begin
                // one fraction bit per squaring
                lm_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                lfrac_reg <= {lfrac_reg[28:0], sq_t[31]};
                iter_reg  <= iter_reg + 5'd1;
            end
            B_LSTORE: begin
                if (!lsel_reg) begin
                    lc_reg   <= l_val;
                    lv_reg   <= {8'd0, db_reg};
                    le_reg   <= 8'sd7;
                    lsel_reg <= 1'b1;
                end else begin
                    delta_reg <= 39'(lc_reg) - 39'(l_val);
                end
            end
            B_LMUL: begin
                lprod_reg <= delta_reg * $signed({1'b0, LN2_Q24});
            end
            B_ASQ: begin
                n_reg    <= 62'h1000_0000_0000_0000 - (a_reg * a_reg);
                res_reg  <= '0;
                one_reg  <= 62'h1000_0000_0000_0000;
                iter_reg <= '0;
            end
            B_SQRT: begin
                if (n_reg >= rt) begin
                    n_reg   <= n_reg - rt;
                    res_reg <= (res_reg >> 1) + one_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                one_reg  <= one_reg >> 2;
                iter_reg <= iter_reg + 5'd1;
            end
            B_VINIT: begin
                x_reg    <= $signed({3'b000, a_reg});
                y_reg    <= $signed({3'b000, res_reg[30:0]});
                ang_reg  <= '0;
                iter_reg <= '0;
            end
            B_VEC: begin
                if (!y_reg[33] && (y_reg != '0)) begin
                    x_reg   <= x_reg + vdx;
                    y_reg   <= y_reg - vdy;
                    ang_reg <= ang_reg + vat;
                end else begin
                    x_reg   <= x_reg - vdx;
                    y_reg   <= y_reg + vdy;
                    ang_reg <= ang_reg - vat;
                end
                iter_reg <= iter_reg + 5'd1;
            end
            B_FIN: begin
                if (out_free) begin
                    out_angle_reg <= angle;
                    out_last_reg  <= last_hit;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/von_mises_rejection_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// von_mises_rejection_sampler_unit: von Mises sampler, Best-Fisher rejection
// Each draw triple is tested against the envelope; accepted draws give
// mean +/- acos(f) as a Q4.28 angle, rejected draws give no beat.
// ----------------------------------------------------------------------------
// The front stage takes one draw triple and works through it in order
// (30-step cosine CORDIC, 31-step division, two partial products for c); it
// then queues the trial once the queue has room and is free for the next
// triple. The back stage takes a queued trial and either rejects it or
// produces an angle once accepted (31-step integer root, 30-step vectoring
// CORDIC), running the log test first when the quadratic test fails or is
// skipped (two log2 evaluations, each up to 40 normalize steps and 30
// squarings). Neither stage takes a new draw before it is through with the
// last one. Results wait in an output register while the
// stages go on. Configuration is taken any cycle but is meant to be written
// only while the block is idle; the run counter is not cleared by writes.
// ----------------------------------------------------------------------------
module von_mises_rejection_sampler_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,     // draw_one[31:0], draw_two[63:32], draw_three[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // sample_angle[31:0]
    output logic        m_tlast,     // last_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import vmrs_pkg::*;

    cfg_regs_t    cfg_reg;
    fifo_status_t fifo_status;
    trial_t       push_data, pop_data;
    logic         push, pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mean_angle    <= '0;
            cfg_reg.concentration <= 32'd65536;
            cfg_reg.envelope_r    <= 32'd106039;
            cfg_reg.sample_count  <= 16'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MEAN:  cfg_reg.mean_angle    <= $signed(cfg_data[30:0]);
                CFG_KAPPA: cfg_reg.concentration <= cfg_data;
                CFG_ENV_R: cfg_reg.envelope_r    <= cfg_data;
                CFG_COUNT: cfg_reg.sample_count  <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    vmrs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .push        (push),
        .push_data   (push_data)
    );

    vmrs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_status)
    );

    vmrs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // checks
    a_fifo_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_status.full && fifo_status.empty))
        else $error("queue reports full and empty at once");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("front pushed into a full queue");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_status.empty)
        else $error("back popped an empty queue");

    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front ready again right after taking a beat");

endmodule
